// ----- rtl/core/mtg_pkg.sv -----
package mtg_pkg;

  localparam int WORD_W       = 32;
  localparam int TABLE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int IDX_W        = $clog2(TABLE_WORDS);
  localparam int CFG_ADDR_W   = 3;

  localparam logic [WORD_W-1:0] MATRIX_A     = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;
  localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_WORDS - 1);

  // Register index, taken from paddr[2]
  localparam logic [0:0] REG_SEED = 1'b0;

  typedef enum logic [1:0] {
    ST_SEED,
    ST_FETCH,
    ST_READY
  } mtg_state_t;

  // One write of the seeding pass
  typedef struct packed {
    logic              en;
    logic              last;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } seed_wr_t;

  // Table index plus a small offset, wrapped once
  function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] idx,
                                                logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, idx} + {1'b0, off};
    if (sum >= (IDX_W+1)'(TABLE_WORDS)) begin
      sum = sum - (IDX_W+1)'(TABLE_WORDS);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] seed_step(logic [WORD_W-1:0] prev,
                                                  logic [IDX_W-1:0]  idx);
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] prod;
    mix  = prev ^ (prev >> 30);
    prod = SEED_MULT * mix;
    return prod + {{(WORD_W-IDX_W){1'b0}}, idx};
  endfunction

  function automatic logic [WORD_W-1:0] twist_word(logic [WORD_W-1:0] cur,
                                                   logic [WORD_W-1:0] nxt,
                                                   logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] v;
    y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ MATRIX_A;
    end
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] temper(logic [WORD_W-1:0] w_in);
    logic [WORD_W-1:0] w;
    w = w_in;
    w = w ^ (w >> 11);
    w = w ^ ((w << 7) & TEMPER_B);
    w = w ^ ((w << 15) & TEMPER_C);
    w = w ^ (w >> 18);
    return w;
  endfunction

endpackage

// ----- rtl/core/mtg_if.sv -----
interface mtg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface mtg_word_if import mtg_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

// ----- rtl/core/mtg_apb_regs.sv -----
module mtg_apb_regs import mtg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0]     pwdata,
  output logic [WORD_W-1:0]     prdata,
  output logic                  pready,
  output logic [WORD_W-1:0]     seed_value
);

  logic wr_en;
  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_SEED);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= DEFAULT_SEED;
    end else if (wr_en && reg_hit) begin
      seed_value <= pwdata;
    end
  end

  assign prdata = reg_hit ? seed_value : '0;

endmodule

// ----- rtl/core/mtg_seeder.sv -----
module mtg_seeder import mtg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] seed,
  output seed_wr_t          seed_wr
);

  logic              busy;
  logic [IDX_W-1:0]  sidx;
  logic [WORD_W-1:0] sword;
  logic [IDX_W-1:0]  sidx_next;

  assign sidx_next = sidx + IDX_W'(1);

  // One table word per cycle: the running value is written, then advanced
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b1;
      sidx  <= '0;
      sword <= DEFAULT_SEED;
    end else if (start) begin
      busy  <= 1'b1;
      sidx  <= '0;
      sword <= (seed == '0) ? DEFAULT_SEED : seed;
    end else if (busy) begin
      busy  <= (sidx != LAST_IDX);
      sidx  <= sidx_next;
      sword <= seed_step(sword, sidx_next);
    end
  end

  assign seed_wr.en   = busy;
  assign seed_wr.last = (sidx == LAST_IDX);
  assign seed_wr.addr = sidx;
  assign seed_wr.data = sword;

endmodule

// ----- rtl/core/mtg_twister.sv -----
module mtg_twister import mtg_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  mtg_req_if.sink         req,
  mtg_word_if.source      rsp,
  input  seed_wr_t        seed_wr,
  output logic            seed_start
);

  logic [WORD_W-1:0] mem [TABLE_WORDS];

  mtg_state_t        state;
  mtg_state_t        state_next;
  logic [IDX_W-1:0]  idx;
  logic [WORD_W-1:0] cur_word;
  logic [WORD_W-1:0] rd_a;
  logic [WORD_W-1:0] rd_b;
  logic              pending;
  logic              out_valid;
  logic [WORD_W-1:0] out_word;

  logic              out_free;
  logic              accept;
  logic              draw;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr_a;
  logic [IDX_W-1:0]  rd_addr_b;
  logic [WORD_W-1:0] new_word;

  assign out_free = !out_valid || rsp.ready;
  assign new_word = twist_word(cur_word, rd_a, rd_b);

  always_comb begin
    state_next = state;
    case (state)
      ST_SEED: begin
        if (seed_wr.en && seed_wr.last) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_READY;
      ST_READY: begin
        if (seed_start) begin
          state_next = ST_SEED;
        end
      end
      default: state_next = ST_SEED;
    endcase
  end

  // rd_a/rd_b always hold entries idx+1 and idx+397 while ready
  always_comb begin
    req.ready  = 1'b0;
    accept     = 1'b0;
    draw       = 1'b0;
    seed_start = 1'b0;
    rd_en      = 1'b0;
    rd_addr_a  = wrap_add(idx, IDX_W'(1));
    rd_addr_b  = wrap_add(idx, IDX_W'(TWIST_OFFSET));
    case (state)
      ST_FETCH: rd_en = 1'b1;
      ST_READY: begin
        req.ready  = !pending && out_free;
        accept     = req.valid && req.ready;
        seed_start = accept && req.restart;
        draw       = out_free && (pending || (accept && !req.restart));
        rd_en      = draw;
        rd_addr_a  = wrap_add(idx, IDX_W'(2));
        rd_addr_b  = wrap_add(idx, IDX_W'(TWIST_OFFSET + 1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SEED;
    end else begin
      state <= state_next;
    end
  end

  // Table: seeding writes or twist-in-place writes, two registered reads
  always_ff @(posedge clk) begin
    if (seed_wr.en) begin
      mem[seed_wr.addr] <= seed_wr.data;
    end else if (draw) begin
      mem[idx] <= new_word;
    end
    if (rd_en) begin
      rd_a <= mem[rd_addr_a];
      rd_b <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (seed_wr.en && (seed_wr.addr == '0)) begin
      cur_word <= seed_wr.data;
    end else if (draw) begin
      cur_word <= rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      pending <= 1'b0;
    end else begin
      if (state == ST_SEED) begin
        idx <= '0;
      end else if (draw) begin
        idx <= wrap_add(idx, IDX_W'(1));
      end
      if (seed_start) begin
        pending <= 1'b1;
      end else if (draw) begin
        pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (draw) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (draw) begin
      out_word <= temper(new_word);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.random_word = out_word;

`ifndef SYNTH
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    draw |-> (rd_addr_a != idx) && (rd_addr_b != idx))
    else $error("table read collides with twist write");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= LAST_IDX)
    else $error("draw index beyond table");

  a_seed_to_fetch: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEED && seed_wr.en && seed_wr.last) |=> state == ST_FETCH)
    else $error("seeding pass end not followed by fetch");

  a_pending_blocks: assert property (@(posedge clk) disable iff (rst)
    pending |-> !req.ready)
    else $error("new item taken while restart draw pending");

  a_seed_only_in_seed: assert property (@(posedge clk) disable iff (rst)
    seed_wr.en |-> state == ST_SEED)
    else $error("seeding write outside seeding state");
`endif

endmodule

// ----- rtl/core/mersenne_twister_generator_top.sv -----
// Channel  Dir  Payload              Handshake
// -------  ---  -------------------  -------------------------------
// req      in   restart (1b)         req.valid / req.ready
// rsp      out  random_word (32b)    rsp.valid / rsp.ready
// apb      in   seed_value (reg 0)   psel, penable, pwrite, pready=1
//
// Steady state: one item per cycle. Each draw twists table entry idx in
// place from registered reads of idx+1 and idx+397 and issues the reads
// for the next draw in the same cycle; the dual-read table sets the pace.
// An item with restart set costs a seeding pass plus a fetch before its
// word is produced; the pass runs one multiply a cycle. After reset the
// same seeding pass plus a fetch runs before the first item is taken.
// Configuration writes are taken at any time. A stalled result holds in
// the output register; new items wait for it.
module mersenne_twister_generator_top import mtg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  mtg_req_if.sink               req,
  mtg_word_if.source            rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0]     pwdata,
  output logic [WORD_W-1:0]     prdata,
  output logic                  pready
);

  logic [WORD_W-1:0] seed_value;
  logic              seed_start;
  seed_wr_t          seed_wr;

  // Seed register; takes effect only at the next restart
  mtg_apb_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .seed_value (seed_value)
  );

  // Seeding pass: writes the initializer sequence, one entry per cycle
  mtg_seeder u_seeder (
    .clk     (clk),
    .rst     (rst),
    .start   (seed_start),
    .seed    (seed_value),
    .seed_wr (seed_wr)
  );

  // Table memory, on-the-fly twist, tempering and output register
  mtg_twister u_twister (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .seed_wr    (seed_wr),
    .seed_start (seed_start)
  );

endmodule
